// File: sv/aicr_pkg.sv
// Shared types and constants for the box pair contact resolver.
`timescale 1ns / 1ps
`default_nettype none
package aicr_pkg;

   localparam int CB     = 20;              // bits per vector component
   localparam int VEC_W  = 3 * CB;          // packed vector width
   localparam int IM_W   = 16;              // inverse mass width
   localparam int RST_W  = 9;               // restitution width
   localparam int EP_W   = 10;              // 256 + restitution
   localparam int M_W    = IM_W + 1;        // inverse mass sum
   localparam int OV_W   = CB + 2;          // signed overlap
   localparam int PP_W   = IM_W + CB;       // inverse mass times penetration
   localparam int EW_W   = EP_W + CB;       // (256 + e) times closing speed
   localparam int NUM_W  = IM_W + EW_W;     // widest dividend
   localparam int DEN_W  = M_W + 8;         // mass sum times 256
   localparam int Q_W    = CB + 1;          // quotient magnitude

   localparam logic [RST_W-1:0] REST_ONE = RST_W'(256);

   localparam logic [1:0] AXIS_NONE = 2'd0;
   localparam logic [1:0] AXIS_X    = 2'd1;
   localparam logic [1:0] AXIS_Y    = 2'd2;
   localparam logic [1:0] AXIS_Z    = 2'd3;

   // Per-item control that travels beside the divider pipeline.
   typedef struct packed {
      logic          valid;
      logic          go;
      logic [1:0]    axis;
      logic          neg;
      logic [CB-1:0] pen;
   } side_type;

endpackage
`default_nettype wire

// File: sv/aicr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module aicr_div #(
   parameter int NUM_BITS = 46,
   parameter int DEN_BITS = 25,
   parameter int QUO_BITS = 21
) (
   input  wire logic                clock,
   input  wire logic                adv,
   input  wire logic [NUM_BITS-1:0] num,
   input  wire logic [DEN_BITS-1:0] den,
   output logic      [QUO_BITS-1:0] quo
);

   localparam int WIDE = NUM_BITS + QUO_BITS;

   logic [NUM_BITS-1:0] rem_ff [1:QUO_BITS];
   logic [DEN_BITS-1:0] den_ff [1:QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [1:QUO_BITS];

   genvar s;
   generate
      for (s = 0; s < QUO_BITS; s++) begin : g_stage
         localparam int B = QUO_BITS - 1 - s;
         logic [NUM_BITS-1:0] rem_cur;
         logic [DEN_BITS-1:0] den_cur;
         logic [QUO_BITS-1:0] quo_cur;
         logic [WIDE-1:0]     trial;
         logic                ge;
         logic [NUM_BITS-1:0] rem_in;
         logic [QUO_BITS-1:0] quo_in;

         if (s == 0) begin : g_first
            assign rem_cur = num;
            assign den_cur = den;
            assign quo_cur = '0;
         end else begin : g_rest
            assign rem_cur = rem_ff[s];
            assign den_cur = den_ff[s];
            assign quo_cur = quo_ff[s];
         end

         always_comb begin
            trial  = WIDE'(den_cur) << B;
            ge     = WIDE'(rem_cur) >= trial;
            rem_in = ge ? (rem_cur - trial[NUM_BITS-1:0]) : rem_cur;
            quo_in = quo_cur;
            quo_in[B] = ge;
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s+1] <= rem_in;
               den_ff[s+1] <= den_cur;
               quo_ff[s+1] <= quo_in;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[QUO_BITS];

endmodule
`default_nettype wire

// File: sv/aabb_impulse_contact_resolve_top.sv
// Box pair contact resolver: contact axis search, impulse and position correction.
//
// Usage: each transfer on the req_ channel carries one box pair (offset and
// relative velocity of B against A, summed half extents, restitutions and
// inverse masses). Each pair produces exactly one transfer on the rsp_ channel
// with the position and velocity deltas of both boxes, the contact axis, the
// normal sign, the penetration depth and a resolved flag.
// The path from a req_ transfer to its result has 27 register stages. The stages
// are five arithmetic stages (overlap, axis select, two multiplier stages,
// rounding), a 21-stage divider pipeline that retires one quotient bit per stage,
// and the output register. Throughput is one pair per cycle while rsp_stall does
// not hold the pipeline; four dividers work side by side on each pair.
// When rsp_stall is high while a result waits, the whole pipeline holds and
// req_stall rises in the same cycle; no item is lost or repeated.
// Reset clears every stage valid bit and rsp_valid; the block accepts a pair
// in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module aabb_impulse_contact_resolve_top
   import aicr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [VEC_W-1:0] req_offset_vec,
   input  wire logic [VEC_W-1:0] req_rel_vel_vec,
   input  wire logic [VEC_W-1:0] req_half_extent_sum_vec,
   input  wire logic [RST_W-1:0] req_restitution_a,
   input  wire logic [RST_W-1:0] req_restitution_b,
   input  wire logic [IM_W-1:0]  req_inv_mass_a,
   input  wire logic [IM_W-1:0]  req_inv_mass_b,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [VEC_W-1:0] rsp_pos_delta_a,
   output logic      [VEC_W-1:0] rsp_pos_delta_b,
   output logic      [VEC_W-1:0] rsp_vel_delta_a,
   output logic      [VEC_W-1:0] rsp_vel_delta_b,
   output logic      [1:0]       rsp_contact_axis,
   output logic                  rsp_normal_negative,
   output logic      [CB-1:0]    rsp_penetration,
   output logic                  rsp_resolved
);

   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Stage 1: per-axis overlap and the clamped, smaller restitution.
   logic                  s1_valid_ff;
   logic signed [OV_W-1:0] s1_ov_ff [3];
   logic                  s1_sgn_ff [3];
   logic signed [CB-1:0]  s1_vel_ff [3];
   logic [IM_W-1:0]       s1_ia_ff, s1_ib_ff;
   logic [RST_W-1:0]      s1_e_ff;
   logic signed [OV_W-1:0] s1_ov_in [3];
   logic [RST_W-1:0]      ra_c, rb_c, e_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [CB-1:0] o;
         logic [CB:0]          a;
         o = signed'(req_offset_vec[i*CB +: CB]);
         a = o[CB-1] ? (CB+1)'(-(CB+1)'(signed'(o))) : (CB+1)'(o);
         s1_ov_in[i] = signed'(OV_W'(req_half_extent_sum_vec[i*CB +: CB])) -
                       signed'(OV_W'(a));
      end
      ra_c = (req_restitution_a > REST_ONE) ? REST_ONE : req_restitution_a;
      rb_c = (req_restitution_b > REST_ONE) ? REST_ONE : req_restitution_b;
      e_in = (ra_c < rb_c) ? ra_c : rb_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s1_ov_ff[i]  <= s1_ov_in[i];
            s1_sgn_ff[i] <= req_offset_vec[i*CB + CB - 1];
            s1_vel_ff[i] <= signed'(req_rel_vel_vec[i*CB +: CB]);
         end
         s1_ia_ff <= req_inv_mass_a;
         s1_ib_ff <= req_inv_mass_b;
         s1_e_ff  <= e_in;
      end
   end

   // Stage 2: contact axis, normal sign and closing speed.
   side_type           s2_in, s2_sb_ff;
   logic [CB-1:0]      w_in, s2_w_ff;
   logic [M_W-1:0]     m_in, s2_m_ff;
   logic [IM_W-1:0]    s2_ia_ff, s2_ib_ff;
   logic [EP_W-1:0]    s2_ep_ff;

   always_comb begin
      logic                  contact;
      logic signed [OV_W-1:0] ovk;
      logic signed [CB-1:0]  velk;
      logic signed [CB:0]    vn;
      contact = (s1_ov_ff[0] > 0) && (s1_ov_ff[1] > 0) && (s1_ov_ff[2] > 0);
      s2_in = '0;
      s2_in.valid = s1_valid_ff;
      priority if (!contact) begin
         s2_in.axis = AXIS_NONE;
      end else if (s1_ov_ff[0] < s1_ov_ff[1] && s1_ov_ff[0] < s1_ov_ff[2]) begin
         s2_in.axis = AXIS_X;
      end else if (s1_ov_ff[1] < s1_ov_ff[0] && s1_ov_ff[1] < s1_ov_ff[2]) begin
         s2_in.axis = AXIS_Y;
      end else if (s1_ov_ff[2] < s1_ov_ff[0] && s1_ov_ff[2] < s1_ov_ff[1]) begin
         s2_in.axis = AXIS_Z;
      end else begin
         s2_in.axis = AXIS_NONE;
      end
      unique case (s2_in.axis)
         AXIS_X: begin
            ovk = s1_ov_ff[0]; velk = s1_vel_ff[0]; s2_in.neg = s1_sgn_ff[0];
         end
         AXIS_Y: begin
            ovk = s1_ov_ff[1]; velk = s1_vel_ff[1]; s2_in.neg = s1_sgn_ff[1];
         end
         AXIS_Z: begin
            ovk = s1_ov_ff[2]; velk = s1_vel_ff[2]; s2_in.neg = s1_sgn_ff[2];
         end
         default: begin
            ovk = '0; velk = '0; s2_in.neg = 1'b0;
         end
      endcase
      s2_in.pen = ovk[CB-1:0];
      vn = s2_in.neg ? -(CB+1)'(velk) : (CB+1)'(velk);
      w_in = CB'(-vn);
      m_in = M_W'(s1_ia_ff) + M_W'(s1_ib_ff);
      s2_in.go = (s2_in.axis != AXIS_NONE) && (vn <= 0) && (m_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_sb_ff <= '0;
      end else if (adv) begin
         s2_sb_ff <= s2_in;
      end
      if (adv) begin
         s2_w_ff  <= w_in;
         s2_m_ff  <= m_in;
         s2_ia_ff <= s1_ia_ff;
         s2_ib_ff <= s1_ib_ff;
         s2_ep_ff <= EP_W'(REST_ONE) + EP_W'(s1_e_ff);
      end
   end

   // Stage 3: position products and restitution times closing speed.
   side_type         s3_sb_ff;
   logic [PP_W-1:0]  s3_pa_ff, s3_pb_ff;
   logic [EW_W-1:0]  s3_ew_ff;
   logic [M_W-1:0]   s3_m_ff;
   logic [IM_W-1:0]  s3_ia_ff, s3_ib_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_sb_ff <= '0;
      end else if (adv) begin
         s3_sb_ff <= s2_sb_ff;
      end
      if (adv) begin
         s3_pa_ff <= PP_W'(s2_ia_ff) * PP_W'(s2_sb_ff.pen);
         s3_pb_ff <= PP_W'(s2_ib_ff) * PP_W'(s2_sb_ff.pen);
         s3_ew_ff <= EW_W'(s2_ep_ff) * EW_W'(s2_w_ff);
         s3_m_ff  <= s2_m_ff;
         s3_ia_ff <= s2_ia_ff;
         s3_ib_ff <= s2_ib_ff;
      end
   end

   // Stage 4: velocity products.
   side_type         s4_sb_ff;
   logic [PP_W-1:0]  s4_pa_ff, s4_pb_ff;
   logic [NUM_W-1:0] s4_va_ff, s4_vb_ff;
   logic [M_W-1:0]   s4_m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_sb_ff <= '0;
      end else if (adv) begin
         s4_sb_ff <= s3_sb_ff;
      end
      if (adv) begin
         s4_va_ff <= NUM_W'(s3_ia_ff) * NUM_W'(s3_ew_ff);
         s4_vb_ff <= NUM_W'(s3_ib_ff) * NUM_W'(s3_ew_ff);
         s4_pa_ff <= s3_pa_ff;
         s4_pb_ff <= s3_pb_ff;
         s4_m_ff  <= s3_m_ff;
      end
   end

   // Stage 5: add half the divisor so the quotient rounds to nearest.
   side_type         sb_ff [0:Q_W];
   logic [NUM_W-1:0] s5_pa_ff, s5_pb_ff, s5_va_ff, s5_vb_ff;
   logic [DEN_W-1:0] s5_mp_ff, s5_mv_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_pa_ff <= NUM_W'(s4_pa_ff) + NUM_W'(s4_m_ff >> 1);
         s5_pb_ff <= NUM_W'(s4_pb_ff) + NUM_W'(s4_m_ff >> 1);
         s5_va_ff <= s4_va_ff + (NUM_W'(s4_m_ff) << 7);
         s5_vb_ff <= s4_vb_ff + (NUM_W'(s4_m_ff) << 7);
         s5_mp_ff <= DEN_W'(s4_m_ff);
         s5_mv_ff <= DEN_W'(s4_m_ff) << 8;
      end
   end

   // Control rides beside the divider stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Q_W; k++) begin
            sb_ff[k] <= '0;
         end
      end else if (adv) begin
         sb_ff[0] <= s4_sb_ff;
         for (int k = 1; k <= Q_W; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   logic [Q_W-1:0] q_pa, q_pb, q_va, q_vb;

   aicr_div #(.NUM_BITS(NUM_W), .DEN_BITS(DEN_W), .QUO_BITS(Q_W)) u_div_pa (
      .clock(clock), .adv(adv), .num(s5_pa_ff), .den(s5_mp_ff), .quo(q_pa));
   aicr_div #(.NUM_BITS(NUM_W), .DEN_BITS(DEN_W), .QUO_BITS(Q_W)) u_div_pb (
      .clock(clock), .adv(adv), .num(s5_pb_ff), .den(s5_mp_ff), .quo(q_pb));
   aicr_div #(.NUM_BITS(NUM_W), .DEN_BITS(DEN_W), .QUO_BITS(Q_W)) u_div_va (
      .clock(clock), .adv(adv), .num(s5_va_ff), .den(s5_mv_ff), .quo(q_va));
   aicr_div #(.NUM_BITS(NUM_W), .DEN_BITS(DEN_W), .QUO_BITS(Q_W)) u_div_vb (
      .clock(clock), .adv(adv), .num(s5_vb_ff), .den(s5_mv_ff), .quo(q_vb));

   // Signed, saturated component from a magnitude.
   function automatic logic [CB-1:0] sat_comp(input logic [Q_W-1:0] mag, input logic negate);
      logic [Q_W-1:0] lim_pos;
      logic [Q_W-1:0] lim_neg;
      logic [CB-1:0]  r;
      lim_pos = Q_W'((1 << (CB - 1)) - 1);
      lim_neg = Q_W'(1 << (CB - 1));
      if (negate) begin
         r = (mag > lim_neg) ? CB'(lim_neg) : CB'(-mag);
      end else begin
         r = (mag > lim_pos) ? CB'(lim_pos) : CB'(mag);
      end
      return r;
   endfunction

   function automatic logic [VEC_W-1:0] place(input logic [CB-1:0] c, input logic [1:0] axis);
      logic [VEC_W-1:0] v;
      unique case (axis)
         AXIS_X:  v = VEC_W'(c);
         AXIS_Y:  v = VEC_W'(c) << CB;
         AXIS_Z:  v = VEC_W'(c) << (2 * CB);
         default: v = '0;
      endcase
      return v;
   endfunction

   side_type         fin;
   logic [CB-1:0]    c_pa, c_pb, c_va, c_vb;
   logic [1:0]       fin_axis;

   always_comb begin
      fin  = sb_ff[Q_W];
      // A moves against the normal, B along it.
      c_pa = fin.go ? sat_comp(q_pa, !fin.neg) : '0;
      c_pb = fin.go ? sat_comp(q_pb, fin.neg)  : '0;
      c_va = fin.go ? sat_comp(q_va, !fin.neg) : '0;
      c_vb = fin.go ? sat_comp(q_vb, fin.neg)  : '0;
      fin_axis = fin.axis;
   end

   logic [VEC_W-1:0] pa_ff, pb_ff, va_ff, vb_ff;
   logic [1:0]       axis_ff;
   logic             neg_ff, res_ff;
   logic [CB-1:0]    pen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin.valid;
      end
      if (adv) begin
         pa_ff   <= place(c_pa, fin_axis);
         pb_ff   <= place(c_pb, fin_axis);
         va_ff   <= place(c_va, fin_axis);
         vb_ff   <= place(c_vb, fin_axis);
         axis_ff <= fin_axis;
         neg_ff  <= (fin_axis != AXIS_NONE) && fin.neg;
         pen_ff  <= (fin_axis != AXIS_NONE) ? fin.pen : '0;
         res_ff  <= (c_pa != '0) || (c_pb != '0) || (c_va != '0) || (c_vb != '0);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pos_delta_a     = pa_ff;
   assign rsp_pos_delta_b     = pb_ff;
   assign rsp_vel_delta_a     = va_ff;
   assign rsp_vel_delta_b     = vb_ff;
   assign rsp_contact_axis    = axis_ff;
   assign rsp_normal_negative = neg_ff;
   assign rsp_penetration     = pen_ff;
   assign rsp_resolved        = res_ff;

endmodule
`default_nettype wire
